/* hdl/spfl_pkg.sv */
// Package for the slot pool free-list allocator.
// Holds the default pool size, the font limit and the request and status codes.
// No dependencies.
package spfl_pkg;

  localparam int SlotsDef  = 64;
  localparam int FontCount = 7;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_BAD_FONT     = 3'd2,
    ST_EMPTY_TEXT   = 3'd3,
    ST_BAD_INDEX    = 3'd4,
    ST_ALREADY_FREE = 3'd5
  } status_e;

endpackage

/* hdl/spfl_link_mem.sv */
// Next-free link memory of the slot pool allocator.
// One write port, one registered read port; unwritten entries read as index plus one.
// Depends on nothing outside this file.
module spfl_link_mem #(
  parameter int Slots = 64,
  parameter int Iw    = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [Iw-1:0] wr_addr_i,
  input  logic [Iw-1:0] wr_data_i,
  input  logic [Iw-1:0] rd_addr_i,
  output logic [Iw-1:0] rd_data_o
);

  logic [Iw-1:0] mem [Slots];
  logic          written_q [Slots];
  logic [Iw-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // An entry never written still holds its reset link.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        written_q[i] <= 1'b0;
      end
      rd_q <= Iw'(1);
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      rd_q <= written_q[rd_addr_i] ? mem[rd_addr_i] : rd_addr_i + Iw'(1);
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* hdl/slot_pool_free_list_allocator_top.sv */
// Slot pool allocator: LIFO free list over a fixed pool of slots.
// A request is held in the input register and its result in the result register.
// Throughput: one request per cycle while the output is not stalled; the head link is prefetched from the link memory.
// Reset: free list holds slots 0 to Slots-1 ascending, all slots vacant, count = Slots.
// Uses spfl_pkg and spfl_link_mem.
module slot_pool_free_list_allocator_top #(
  parameter int Slots = spfl_pkg::SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // slot_index[6:0], font_code[10:7], first_char[18:11]
  input  logic        s_axis_tuser_i,   // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // granted_slot[5:0], status[8:6], slots_left[15:9]
);

  localparam int Iw = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int Cw = $clog2(Slots + 1);

  // Input register
  logic                 s1_vld_q;
  spfl_pkg::action_e    s1_act_q;
  logic [6:0]           s1_idx_q;
  logic [3:0]           s1_font_q;
  logic [7:0]           s1_char_q;
  logic                 s1_vac_q;

  // Result register
  logic                 out_vld_q;
  logic [15:0]          out_data_q;

  // Free list state
  logic [Iw-1:0]        head_q, head_d;
  logic [Cw-1:0]        count_q, count_d;
  logic                 vacant_q [Slots];
  logic [Iw-1:0]        byp_q;
  logic                 byp_sel_q;

  logic                 advance;
  logic [Iw-1:0]        link;
  logic [Iw-1:0]        rd_data;
  logic [Iw-1:0]        idx_w;
  logic [Iw-1:0]        in_idx_w;
  logic                 in_vac;
  logic                 do_alloc, do_free;
  spfl_pkg::status_e    status;
  logic [5:0]           granted;

  assign advance         = s1_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_vld_q || advance;
  assign link            = byp_sel_q ? byp_q : rd_data;
  assign idx_w           = Iw'(s1_idx_q);
  assign in_idx_w        = Iw'(s_axis_tdata_i[6:0]);

  // Look up the vacancy of the incoming slot; forward the update made at this edge.
  always_comb begin
    in_vac = vacant_q[in_idx_w];
    if (do_alloc && head_q == in_idx_w) begin
      in_vac = 1'b0;
    end else if (do_free && idx_w == in_idx_w) begin
      in_vac = 1'b1;
    end
  end

  always_comb begin
    status   = spfl_pkg::ST_OK;
    do_alloc = 1'b0;
    do_free  = 1'b0;
    if (s1_act_q == spfl_pkg::ACT_ALLOC) begin
      if (count_q == '0) begin
        status = spfl_pkg::ST_EMPTY;
      end else if (s1_font_q >= 4'(spfl_pkg::FontCount)) begin
        status = spfl_pkg::ST_BAD_FONT;
      end else if (s1_char_q == 8'd0) begin
        status = spfl_pkg::ST_EMPTY_TEXT;
      end else begin
        do_alloc = advance;
      end
    end else begin
      if (32'(s1_idx_q) >= Slots) begin
        status = spfl_pkg::ST_BAD_INDEX;
      end else if (s1_vac_q) begin
        status = spfl_pkg::ST_ALREADY_FREE;
      end else begin
        do_free = advance;
      end
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    granted = 6'd0;
    if (do_alloc) begin
      head_d  = link;
      count_d = count_q - Cw'(1);
      granted = 6'(head_q);
    end else if (do_free) begin
      head_d  = idx_w;
      count_d = count_q + Cw'(1);
    end
  end

  // Read the link of the next head; a push forwards the old head directly.
  spfl_link_mem #(
    .Slots (Slots),
    .Iw    (Iw)
  ) u_link_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (do_free),
    .wr_addr_i (idx_w),
    .wr_data_i (head_q),
    .rd_addr_i (head_d),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      head_q    <= '0;
      count_q   <= Cw'(Slots);
      byp_sel_q <= 1'b0;
      for (int i = 0; i < Slots; i++) begin
        vacant_q[i] <= 1'b1;
      end
    end else begin
      if (s_axis_tready_o) begin
        s1_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      head_q    <= head_d;
      count_q   <= count_d;
      byp_sel_q <= do_free;
      if (do_alloc) begin
        vacant_q[head_q] <= 1'b0;
      end else if (do_free) begin
        vacant_q[idx_w] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      s1_act_q  <= spfl_pkg::action_e'(s_axis_tuser_i);
      s1_idx_q  <= s_axis_tdata_i[6:0];
      s1_font_q <= s_axis_tdata_i[10:7];
      s1_char_q <= s_axis_tdata_i[18:11];
      s1_vac_q  <= in_vac;
    end
    if (do_free) begin
      byp_q <= head_q;
    end
    if (advance) begin
      out_data_q <= {7'(count_d), status, granted};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(count_q) <= Slots)
    else $error("free count above pool size");

  assert property (@(posedge clk_i) disable iff (!rst_ni) do_alloc |-> vacant_q[head_q])
    else $error("allocated slot was not vacant");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_free |=> count_q == $past(count_q) + Cw'(1) && head_q == $past(idx_w))
    else $error("push did not update head and count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_alloc || do_free) |-> advance)
    else $error("state changed without a request advancing");

endmodule
